/* hw/rtl/serial_command_frame_decoder_macros.svh */
// Assertion macros for the serial command frame decoder.
// Expects clk and arst_n in the scope of each use.
`ifndef SERIAL_COMMAND_FRAME_DECODER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SCFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SCFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/scfd_pkg.sv */
// Shared types, command codes and tables for the serial command frame decoder.
// No dependencies.
package scfd_pkg;

	localparam logic [7:0] SIG_RESET = 8'hC0;
	localparam logic [7:0] CMD_COUNT = 8'd5;

	typedef enum logic [2:0] {
		CMD_PING       = 3'd0,
		CMD_SET_OUTPUT = 3'd1,
		CMD_SET_SERVO  = 3'd2,
		CMD_STEP_MOTOR = 3'd3,
		CMD_STOP_MOTOR = 3'd4
	} cmd_e;

	typedef enum logic [2:0] {
		CNT_WAIT_SIG = 3'd0,
		CNT_WAIT_CMD = 3'd1
	} cnt_code_e;

	typedef struct packed {
		logic [2:0]  command_code;
		logic [7:0]  first_param;
		logic [3:0]  channel_bank;
		logic [3:0]  channel_pin;
		logic        output_level;
		logic [15:0] servo_duty;
		logic [7:0]  step_delay;
		logic [15:0] step_count;
	} result_t;

	function automatic logic [2:0] param_len(input logic [2:0] cmd);
		logic [2:0] len;
		case (cmd)
			CMD_PING:       len = 3'd1;
			CMD_SET_OUTPUT: len = 3'd2;
			CMD_SET_SERVO:  len = 3'd3;
			CMD_STEP_MOTOR: len = 3'd4;
			CMD_STOP_MOTOR: len = 3'd1;
			default:        len = 3'd1;
		endcase
		return len;
	endfunction

endpackage

/* hw/rtl/scfd_apb.sv */
// APB register port holding the frame signature.
// Depends on scfd_pkg.
module scfd_apb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  signature
);

	logic [7:0] signature_q;
	logic       sel_sig;

	assign sel_sig   = (paddr[2] == 1'b0);
	assign pready    = 1'b1;
	assign signature = signature_q;
	assign prdata    = sel_sig ? {24'd0, signature_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signature_q <= scfd_pkg::SIG_RESET;
		end else if (psel && penable && pwrite && pready && sel_sig) begin
			signature_q <= pwdata[7:0];
		end
	end

endmodule

/* hw/rtl/scfd_frame.sv */
// Frame tracker: byte count, held command, parameter store, result decode.
// Depends on scfd_pkg and serial_command_frame_decoder_macros.svh.
`include "serial_command_frame_decoder_macros.svh"

module scfd_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            signature,
	output logic                  done,
	output scfd_pkg::result_t     result
);

	logic [2:0] bytes_received_q;
	logic [2:0] held_command_q;
	logic [7:0] param_q [4];
	logic [2:0] cnt_next;
	logic [2:0] cmd_next;
	logic [2:0] cnt_less;
	logic [1:0] idx;
	logic [7:0] p [4];
	logic       in_params;

	assign in_params = (bytes_received_q != scfd_pkg::CNT_WAIT_SIG) &&
		(bytes_received_q != scfd_pkg::CNT_WAIT_CMD);
	assign cnt_less = bytes_received_q - 3'd2;
	assign idx      = cnt_less[1:0];
	assign done     = in_params &&
		((bytes_received_q - 3'd1) >= scfd_pkg::param_len(held_command_q));

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			p[k] = (idx == k[1:0]) ? rx_byte : param_q[k];
		end
	end

	always_comb begin
		cnt_next = bytes_received_q;
		cmd_next = held_command_q;
		case (bytes_received_q)
			scfd_pkg::CNT_WAIT_SIG: begin
				if (rx_byte == signature) cnt_next = scfd_pkg::CNT_WAIT_CMD;
			end
			scfd_pkg::CNT_WAIT_CMD: begin
				if (rx_byte < scfd_pkg::CMD_COUNT) begin
					cmd_next = rx_byte[2:0];
					cnt_next = 3'd2;
				end else begin
					cnt_next = scfd_pkg::CNT_WAIT_SIG;
				end
			end
			default: begin
				cnt_next = done ? 3'(scfd_pkg::CNT_WAIT_SIG) : bytes_received_q + 3'd1;
			end
		endcase
	end

	always_comb begin
		result              = '0;
		result.command_code = held_command_q;
		result.first_param  = p[0];
		result.channel_bank = p[0][7:4];
		result.channel_pin  = p[0][3:0];
		if (held_command_q == scfd_pkg::CMD_SET_OUTPUT) result.output_level = p[1][0];
		if (held_command_q == scfd_pkg::CMD_SET_SERVO) result.servo_duty = {p[1], p[2]};
		if (held_command_q == scfd_pkg::CMD_STEP_MOTOR) begin
			result.step_delay = p[1];
			result.step_count = {p[2], p[3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_received_q <= 3'd0;
			held_command_q   <= 3'd0;
		end else if (step) begin
			bytes_received_q <= cnt_next;
			held_command_q   <= cmd_next;
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_params) begin
			param_q[idx] <= rx_byte;
		end
	end

	`SCFD_ASSERT_NOW(a_cnt_range, 1'b1, bytes_received_q <= 3'd5, "byte count out of range")
	`SCFD_ASSERT_NOW(a_cmd_valid, in_params, held_command_q < 3'd5, "held command invalid")
	`SCFD_ASSERT_NEXT(a_done_clears, step && done, bytes_received_q == 3'd0, "count not cleared")
	`SCFD_ASSERT_NOW(a_done_in_params, done, in_params, "result outside parameter phase")

endmodule

/* hw/rtl/serial_command_frame_decoder.sv */
// Top level of the serial command frame decoder: input stage, output register.
// Depends on scfd_pkg, scfd_apb and scfd_frame.
//
// Takes one received byte per transaction and emits one decoded command when
// the last parameter byte of a valid frame arrives. A byte is accepted every
// cycle unless the input stalls: each byte is held in the input register, is
// decoded against the frame state there and, if it completes a frame, lands
// in the output register. The input stalls only while a finished result waits
// in the output register, out_stall is high and the input register is full.
// The frame signature (reset 0xC0) lies at address 0.
module serial_command_frame_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         command_code,
	output logic [7:0]         first_param,
	output logic [3:0]         channel_bank,
	output logic [3:0]         channel_pin,
	output logic               output_level,
	output logic [15:0]        servo_duty,
	output logic [7:0]         step_delay,
	output logic signed [15:0] step_count
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	scfd_pkg::result_t result_q;
	scfd_pkg::result_t result;
	logic              done;
	logic              out_ready;
	logic              step;
	logic              in_accept;
	logic [7:0]        signature;

	assign out_ready = !out_valid_q || !out_stall;
	assign step      = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_accept = in_valid && !in_stall;

	scfd_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.signature (signature)
	);

	scfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.signature (signature),
		.done      (done),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) valid_s1 <= 1'b1;
			else if (step) valid_s1 <= 1'b0;
			if (out_ready) out_valid_q <= step && done;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) byte_s1 <= rx_byte;
		if (step && done) result_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign command_code = result_q.command_code;
	assign first_param  = result_q.first_param;
	assign channel_bank = result_q.channel_bank;
	assign channel_pin  = result_q.channel_pin;
	assign output_level = result_q.output_level;
	assign servo_duty   = result_q.servo_duty;
	assign step_delay   = result_q.step_delay;
	assign step_count   = result_q.step_count;

endmodule
